FILE: rtl/core/pidc_pkg.sv
// Shared widths, codes and transaction types of the clamped PID controller.
package pidc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int MEAS_W      = 18;
    localparam int ERR_W       = 18;
    localparam int DERIV_W     = 19;
    localparam int INTEG_W     = 21;
    localparam int INTEG_SUM_W = 22;
    localparam int ILIM_W      = 20;
    localparam int OLIM_W      = 16;
    localparam int OUT_W       = 17;
    localparam int PROD_P_W    = 34;
    localparam int PROD_I_W    = 37;
    localparam int PROD_D_W    = 35;
    localparam int ACC_W       = 39;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic signed [INTEG_W-1:0] INTEG_RESET = 21'sd120;
    localparam logic [OLIM_W-1:0]         OLIM_RESET  = 16'd7200;
    localparam logic [ILIM_W-1:0]         ILIM_RESET  = 20'd7200;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd6;

    typedef enum logic [1:0] {
        MODE_DIRECT     = 2'd0,
        MODE_ABS_AVG    = 2'd1,
        MODE_ABS_SUM    = 2'd2,
        MODE_SIGNED_AVG = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic signed [SAMPLE_W-1:0] setpoint;
        logic [OLIM_W-1:0]          output_limit;
        logic [ILIM_W-1:0]          integral_limit;
        t_mode                      mode;
    } t_cfg;

    typedef struct packed {
        logic                      skip;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } t_job;

endpackage

FILE: rtl/core/pid_controller_clamped_unit.sv
// Path: front error register, queue slot, back product, sum and output registers.
// Throughput: one transaction per cycle while nothing stalls, set by the integral
// update in the front end and the product, sum and saturation registers in the back
// end. A four-entry queue lets front and back stall independently.
// Reset (synchronous, active low): registers to defaults, integral to 120,
// previous error and held output to zero; no clearing pass.
module pid_controller_clamped_unit import pidc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample_a,
    input  logic signed [SAMPLE_W-1:0]  i_sample_b,
    input  logic                        i_skip_update,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_drive_out
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    t_job push_job;
    logic q_valid;
    logic q_pop;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.setpoint       <= '0;
            r_cfg.output_limit   <= OLIM_RESET;
            r_cfg.integral_limit <= ILIM_RESET;
            r_cfg.mode           <= MODE_DIRECT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:   r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                CFG_SETPOINT: r_cfg.setpoint       <= i_cfg_data[SAMPLE_W-1:0];
                CFG_OLIM:     r_cfg.output_limit   <= i_cfg_data[OLIM_W-1:0];
                CFG_ILIM:     r_cfg.integral_limit <= i_cfg_data[ILIM_W-1:0];
                CFG_MODE:     r_cfg.mode           <= t_mode'(i_cfg_data[1:0]);
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    pidc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_skip_update (i_skip_update),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    pidc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    pidc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_job     (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive_out (o_drive_out)
    );

endmodule

FILE: rtl/core/pidc_front.sv
// Front end: accept a transaction, form the error and advance the integral state.
module pidc_front import pidc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    input  logic                       i_skip_update,
    input  logic                       i_q_full,
    output logic                       o_push,
    output t_job                       o_job
);

    logic signed [SAMPLE_W:0]      ext_a;
    logic signed [SAMPLE_W:0]      ext_b;
    logic [SAMPLE_W:0]             abs_a;
    logic [SAMPLE_W:0]             abs_b;
    logic [SAMPLE_W+1:0]           abs_sum;
    logic signed [SAMPLE_W:0]      sgn_sum;
    logic signed [SAMPLE_W:0]      sgn_adj;
    logic signed [SAMPLE_W:0]      sgn_half;
    logic signed [MEAS_W-1:0]      meas;
    logic signed [ERR_W-1:0]       n_err;

    logic                          r_vld;
    logic                          r_skip;
    logic signed [ERR_W-1:0]       r_err;
    logic signed [INTEG_W-1:0]     r_integ;
    logic signed [ERR_W-1:0]       r_prev_err;

    logic signed [INTEG_SUM_W-1:0] integ_sum;
    logic signed [INTEG_SUM_W-1:0] ilim_pos;
    logic signed [INTEG_SUM_W-1:0] ilim_neg;
    logic signed [INTEG_SUM_W-1:0] integ_clamped;
    logic signed [INTEG_W-1:0]     n_integ;
    logic signed [DERIV_W-1:0]     deriv;

    assign ext_a    = {i_sample_a[SAMPLE_W-1], i_sample_a};
    assign ext_b    = {i_sample_b[SAMPLE_W-1], i_sample_b};
    assign abs_a    = ext_a[SAMPLE_W] ? (-ext_a) : ext_a;
    assign abs_b    = ext_b[SAMPLE_W] ? (-ext_b) : ext_b;
    assign abs_sum  = {1'b0, abs_a} + {1'b0, abs_b};
    assign sgn_sum  = ext_a + ext_b;
    assign sgn_adj  = sgn_sum + {{SAMPLE_W{1'b0}}, sgn_sum[SAMPLE_W]};
    assign sgn_half = sgn_adj >>> 1;

    always_comb begin
        unique case (i_cfg.mode)
            MODE_DIRECT:     meas = {{(MEAS_W-SAMPLE_W){i_sample_a[SAMPLE_W-1]}}, i_sample_a};
            MODE_ABS_AVG:    meas = {1'b0, abs_sum[SAMPLE_W+1:1]};
            MODE_ABS_SUM:    meas = abs_sum;
            MODE_SIGNED_AVG: meas = {sgn_half[SAMPLE_W], sgn_half};
            default:         meas = '0;
        endcase
    end

    assign n_err = {{(ERR_W-SAMPLE_W){i_cfg.setpoint[SAMPLE_W-1]}}, i_cfg.setpoint} - meas;

    assign o_push     = r_vld && !i_q_full;
    assign o_in_ready = !r_vld || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_err  <= n_err;
            r_skip <= i_skip_update;
        end
    end

    assign integ_sum = {r_integ[INTEG_W-1], r_integ}
                     + {{(INTEG_SUM_W-ERR_W){r_err[ERR_W-1]}}, r_err};
    assign ilim_pos  = {{(INTEG_SUM_W-ILIM_W){1'b0}}, i_cfg.integral_limit};
    assign ilim_neg  = -ilim_pos;

    always_comb begin
        if (integ_sum > ilim_pos) begin
            integ_clamped = ilim_pos;
        end else if (integ_sum < ilim_neg) begin
            integ_clamped = ilim_neg;
        end else begin
            integ_clamped = integ_sum;
        end
    end

    assign n_integ = integ_clamped[INTEG_W-1:0];
    assign deriv   = {r_err[ERR_W-1], r_err} - {r_prev_err[ERR_W-1], r_prev_err};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= INTEG_RESET;
            r_prev_err <= '0;
        end else if (o_push && !r_skip) begin
            r_integ    <= n_integ;
            r_prev_err <= r_err;
        end
    end

    assign o_job.skip  = r_skip;
    assign o_job.err   = r_err;
    assign o_job.integ = n_integ;
    assign o_job.deriv = deriv;

endmodule

FILE: rtl/core/pidc_queue.sv
// Short transaction queue between the front end and the back end.
module pidc_queue import pidc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/pidc_back.sv
// Back end: gain products, sum, output saturation and held output.
module pidc_back import pidc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_valid,
    input  t_job                    i_q_job,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_drive_out
);

    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [ERR_W-1:0]    job_err;
    logic signed [INTEG_W-1:0]  job_integ;
    logic signed [DERIV_W-1:0]  job_deriv;
    logic signed [PROD_P_W-1:0] n_pp;
    logic signed [PROD_I_W-1:0] n_pi;
    logic signed [PROD_D_W-1:0] n_pd;

    logic                       r1_vld;
    logic                       r1_skip;
    logic signed [PROD_P_W-1:0] r1_pp;
    logic signed [PROD_I_W-1:0] r1_pi;
    logic signed [PROD_D_W-1:0] r1_pd;

    logic                       r2_vld;
    logic                       r2_skip;
    logic signed [ACC_W-1:0]    r2_acc;
    logic signed [ACC_W-1:0]    n_acc;

    logic                       r_out_vld;
    logic signed [OUT_W-1:0]    r_drive;
    logic signed [OUT_W-1:0]    r_held;

    logic signed [ACC_W-1:0]    olim_pos;
    logic signed [ACC_W-1:0]    olim_neg;
    logic signed [ACC_W-1:0]    acc_clamped;
    logic signed [OUT_W-1:0]    n_drive;

    logic                       adv3;
    logic                       ready2;
    logic                       adv2;
    logic                       ready1;

    assign adv3   = r2_vld && (!r_out_vld || i_out_ready);
    assign ready2 = !r2_vld || adv3;
    assign adv2   = r1_vld && ready2;
    assign ready1 = !r1_vld || adv2;
    assign o_pop  = i_q_valid && ready1;

    assign gain_p    = i_cfg.gain_p;
    assign gain_i    = i_cfg.gain_i;
    assign gain_d    = i_cfg.gain_d;
    assign job_err   = i_q_job.err;
    assign job_integ = i_q_job.integ;
    assign job_deriv = i_q_job.deriv;

    assign n_pp = gain_p * job_err;
    assign n_pi = gain_i * job_integ;
    assign n_pd = gain_d * job_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (ready1) begin
            r1_vld <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r1_skip <= i_q_job.skip;
            r1_pp   <= n_pp;
            r1_pi   <= n_pi;
            r1_pd   <= n_pd;
        end
    end

    assign n_acc = {{(ACC_W-PROD_P_W){r1_pp[PROD_P_W-1]}}, r1_pp}
                 + {{(ACC_W-PROD_I_W){r1_pi[PROD_I_W-1]}}, r1_pi}
                 + {{(ACC_W-PROD_D_W){r1_pd[PROD_D_W-1]}}, r1_pd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (ready2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_skip <= r1_skip;
            r2_acc  <= n_acc;
        end
    end

    assign olim_pos = {{(ACC_W-OLIM_W){1'b0}}, i_cfg.output_limit};
    assign olim_neg = -olim_pos;

    always_comb begin
        if (r2_acc > olim_pos) begin
            acc_clamped = olim_pos;
        end else if (r2_acc < olim_neg) begin
            acc_clamped = olim_neg;
        end else begin
            acc_clamped = r2_acc;
        end
    end

    assign n_drive = r2_skip ? r_held : acc_clamped[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_held    <= '0;
        end else begin
            if (adv3) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (adv3 && !r2_skip) begin
                r_held <= acc_clamped[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_drive <= n_drive;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive_out = r_drive;

endmodule
